[rtl/core/i2cm_pkg.sv]
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master bit engine: command codes,
// sequencer states, beat payload structs and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

   // default width of the bus delay counter
   localparam int DELAY_WIDTH_DEFAULT = 16;

   // reset value of the half period register
   localparam logic [15:0] HALF_PERIOD_RESET = 16'd400;

   // bits in one data byte
   localparam logic [3:0] BYTE_BITS = 4'd8;
   localparam logic [3:0] LAST_BIT  = 4'd7;

   // command codes carried in the kind field
   typedef enum logic [3:0] {
      KIND_NONE    = 4'd0,
      KIND_START   = 4'd1,
      KIND_STOP    = 4'd2,
      KIND_WRITE   = 4'd3,
      KIND_READ    = 4'd4,
      KIND_WAITACK = 4'd5,
      KIND_ACK     = 4'd6,
      KIND_NACK    = 4'd7,
      KIND_CHECK   = 4'd8
   } kind_type;

   // line sequence being run, one-hot
   typedef enum logic [7:0] {
      PRIM_IDLE    = 8'b0000_0001,
      PRIM_START   = 8'b0000_0010,
      PRIM_STOP    = 8'b0000_0100,
      PRIM_WRITE   = 8'b0000_1000,
      PRIM_READ    = 8'b0001_0000,
      PRIM_WAITACK = 8'b0010_0000,
      PRIM_ACK     = 8'b0100_0000,
      PRIM_NACK    = 8'b1000_0000
   } prim_type;

   // outcome of one sequencer step
   typedef enum logic [1:0] {
      STEP_DELAY = 2'd0,
      STEP_GO    = 2'd1,
      STEP_END   = 2'd2
   } step_res_type;

   // sequencer state plus per-step scratch flags
   typedef struct packed {
      prim_type     prim;
      logic         check_mode;
      logic [2:0]   phase;
      logic [3:0]   bit_index;
      logic [7:0]   shift;
      logic         scl;
      logic         sda;
      logic [7:0]   read_result;
      logic         ack;
      logic         load_delay;
      step_res_type res;
      logic         done;
   } eng_state_type;

   // input beat
   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] data_byte;
      logic       sda_in;
      logic       scl_in;
   } req_payload_type;

   // result beat
   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_bit;
   } rsp_payload_type;

endpackage

`default_nettype wire

[rtl/core/i2c_master_bit_engine.sv]
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// Open-drain I2C master bit sequencer, one input beat per bus sample tick.
//
// Each req beat is one tick: an optional command (start, stop, write, read,
// wait ack, send ack, send nack, check device) plus the sampled SDA and SCL.
// A command is taken only when the engine is idle; one that arrives while
// busy is dropped. Every bus level is held for one delay of half_period_ticks
// ticks, set through the csr write port (reset 400); the user must write it
// only while the engine is idle, which the block itself does not enforce.
// Every req beat yields exactly one rsp beat with the line drives, busy,
// a done pulse, the last read byte and the ack flag.
// The rsp beat is registered at the edge that takes the req beat. Throughput
// is one beat per cycle while rsp_ready does not hold the result register;
// the step logic between the state registers and the result register is at
// most two sequencer steps deep.
// When rsp_ready is low the result register holds; req_ready stays high
// while the result register is empty or being drained, so a stall costs
// no beats. Reset releases both lines, sets the ack flag, clears the
// sequencer and empties the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_engine #(
   parameter int DELAY_WIDTH = i2cm_pkg::DELAY_WIDTH_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire i2cm_pkg::req_payload_type req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output i2cm_pkg::rsp_payload_type      rsp_data,
   input  wire logic                      csr_write_en,
   input  wire logic [15:0]               csr_write_data
);
   import i2cm_pkg::*;

   // one phase of the current line sequence
   function automatic eng_state_type run_phase(eng_state_type s, logic sda_smp);
      eng_state_type n;
      n = s;
      n.load_delay = 1'b0;
      n.res = STEP_END;
      unique case (s.prim)
         PRIM_START, PRIM_STOP: begin
            if (s.phase < 3'd3) begin
               n.load_delay = 1'b1;
               n.res = STEP_DELAY;
               n.phase = s.phase + 3'd1;
            end
            if (s.prim == PRIM_START) begin
               case (s.phase)
                  3'd0: begin
                     n.sda = 1'b1;
                     n.scl = 1'b1;
                  end
                  3'd1: n.sda = 1'b0;
                  3'd2: n.scl = 1'b0;
                  default: ;
               endcase
            end else begin
               case (s.phase)
                  3'd0: n.sda = 1'b0;
                  3'd1: n.scl = 1'b1;
                  3'd2: n.sda = 1'b1;
                  default: ;
               endcase
            end
         end
         PRIM_WRITE: begin
            if (s.phase == 3'd0) begin
               n.sda = s.shift[7];
               n.load_delay = 1'b1;
               n.res = STEP_DELAY;
               n.phase = 3'd1;
            end else if (s.phase == 3'd1) begin
               n.scl = 1'b1;
               n.load_delay = 1'b1;
               n.res = STEP_DELAY;
               n.phase = 3'd2;
            end else begin
               n.scl = 1'b0;
               if (s.bit_index >= LAST_BIT) begin
                  n.sda = 1'b1;
               end
               n.shift = {s.shift[6:0], 1'b0};
               n.bit_index = s.bit_index + 4'd1;
               if (n.bit_index >= BYTE_BITS) begin
                  n.res = STEP_END;
               end else begin
                  n.phase = 3'd0;
                  n.res = STEP_GO;
               end
            end
         end
         PRIM_READ: begin
            if (s.phase == 3'd0) begin
               n.scl = 1'b1;
               n.load_delay = 1'b1;
               n.res = STEP_DELAY;
               n.phase = 3'd1;
            end else if (s.phase == 3'd1) begin
               n.shift = {s.shift[6:0], sda_smp};
               n.scl = 1'b0;
               n.bit_index = s.bit_index + 4'd1;
               n.load_delay = 1'b1;
               n.res = STEP_DELAY;
               n.phase = 3'd2;
            end else if (s.bit_index >= BYTE_BITS) begin
               n.read_result = s.shift;
               n.res = STEP_END;
            end else begin
               n.phase = 3'd0;
               n.res = STEP_GO;
            end
         end
         PRIM_WAITACK: begin
            if (s.phase < 3'd3) begin
               n.load_delay = 1'b1;
               n.res = STEP_DELAY;
               n.phase = s.phase + 3'd1;
            end
            case (s.phase)
               3'd0: n.sda = 1'b1;
               3'd1: n.scl = 1'b1;
               3'd2: begin
                  n.ack = sda_smp;
                  n.scl = 1'b0;
               end
               default: ;
            endcase
         end
         PRIM_ACK, PRIM_NACK: begin
            if (s.phase < 3'd3 || (s.phase == 3'd3 && s.prim == PRIM_ACK)) begin
               n.load_delay = 1'b1;
               n.res = STEP_DELAY;
               n.phase = s.phase + 3'd1;
            end
            case (s.phase)
               3'd0: n.sda = (s.prim == PRIM_NACK);
               3'd1: n.scl = 1'b1;
               3'd2: n.scl = 1'b0;
               3'd3: begin
                  if (s.prim == PRIM_ACK) begin
                     n.sda = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         default: n.res = STEP_END;
      endcase
      return n;
   endfunction

   // end of a sequence: chain the next one for check device, else finish
   function automatic eng_state_type resolve_end(eng_state_type s);
      eng_state_type n;
      n = s;
      if (s.res == STEP_END) begin
         if (s.check_mode && s.prim != PRIM_STOP) begin
            if (s.prim == PRIM_START) begin
               n.prim = PRIM_WRITE;
            end else if (s.prim == PRIM_WRITE) begin
               n.prim = PRIM_WAITACK;
            end else begin
               n.prim = PRIM_STOP;
            end
            n.phase = 3'd0;
            n.bit_index = 4'd0;
            n.res = STEP_GO;
         end else begin
            n.prim = PRIM_IDLE;
            n.check_mode = 1'b0;
            n.phase = 3'd0;
            n.done = 1'b1;
         end
      end
      return n;
   endfunction

   // run steps until a delay starts or the command ends (two at most)
   function automatic eng_state_type advance(eng_state_type s, logic sda_smp);
      eng_state_type n;
      logic          loaded;
      n = s;
      n.done = 1'b0;
      n = resolve_end(run_phase(n, sda_smp));
      loaded = n.load_delay;
      if (n.res == STEP_GO) begin
         n = resolve_end(run_phase(n, sda_smp));
         loaded = loaded | n.load_delay;
      end
      n.load_delay = loaded;
      return n;
   endfunction

   // registers
   eng_state_type          st_ff, st_in;
   logic [DELAY_WIDTH-1:0] delay_ff, delay_in;
   logic [15:0]            half_period_ff;
   logic                   rsp_valid_ff;
   rsp_payload_type        rsp_data_ff, rsp_data_in;

   logic                   req_fire;
   logic [15:0]            half_m1;
   logic [31:0]            half_m1_wide;
   logic [31:0]            delay_lim;
   logic [DELAY_WIDTH-1:0] delay_load;
   logic                   busy;
   eng_state_type          st_step;

   assign req_fire  = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign busy      = (st_ff.prim != PRIM_IDLE);

   // reload value for one bus delay: zero acts as one, saturate to counter width
   assign half_m1      = (half_period_ff == 16'd0) ? 16'd0 : half_period_ff - 16'd1;
   assign half_m1_wide = 32'(half_m1);
   assign delay_lim    = 32'({DELAY_WIDTH{1'b1}});
   assign delay_load   = DELAY_WIDTH'((half_m1_wide > delay_lim) ? delay_lim : half_m1_wide);

   // next state for one tick
   always_comb begin
      st_in   = st_ff;
      st_step = st_ff;
      st_in.done = 1'b0;
      st_in.load_delay = 1'b0;
      delay_in = delay_ff;
      if (busy) begin
         if (delay_ff != '0) begin
            delay_in = delay_ff - DELAY_WIDTH'(1);
         end else begin
            st_in = advance(st_ff, req_data.sda_in);
         end
      end else begin
         st_step.bit_index = 4'd0;
         st_step.phase = 3'd0;
         st_step.check_mode = 1'b0;
         unique case (req_data.kind)
            KIND_NONE: ;
            KIND_START: begin
               st_step.prim = PRIM_START;
               st_in = advance(st_step, req_data.sda_in);
            end
            KIND_STOP: begin
               st_step.prim = PRIM_STOP;
               st_in = advance(st_step, req_data.sda_in);
            end
            KIND_WRITE: begin
               st_step.prim = PRIM_WRITE;
               st_step.shift = req_data.data_byte;
               st_in = advance(st_step, req_data.sda_in);
            end
            KIND_READ: begin
               st_step.prim = PRIM_READ;
               st_step.shift = 8'd0;
               st_in = advance(st_step, req_data.sda_in);
            end
            KIND_WAITACK: begin
               st_step.prim = PRIM_WAITACK;
               st_in = advance(st_step, req_data.sda_in);
            end
            KIND_ACK: begin
               st_step.prim = PRIM_ACK;
               st_in = advance(st_step, req_data.sda_in);
            end
            KIND_NACK: begin
               st_step.prim = PRIM_NACK;
               st_in = advance(st_step, req_data.sda_in);
            end
            KIND_CHECK: begin
               if (req_data.sda_in && req_data.scl_in) begin
                  st_step.prim = PRIM_START;
                  st_step.check_mode = 1'b1;
                  st_step.shift = req_data.data_byte;
                  st_in = advance(st_step, req_data.sda_in);
               end else begin
                  // bus not idle: report no response at once
                  st_in = st_step;
                  st_in.ack = 1'b1;
                  st_in.done = 1'b1;
                  st_in.load_delay = 1'b0;
               end
            end
            default: ;
         endcase
      end
      if (st_in.load_delay) begin
         delay_in = delay_load;
      end
   end

   // result beat built from the state after this tick
   always_comb begin
      rsp_data_in.scl_out  = st_in.scl;
      rsp_data_in.sda_out  = st_in.sda;
      rsp_data_in.busy_res = (st_in.prim != PRIM_IDLE);
      rsp_data_in.done_res = st_in.done;
      rsp_data_in.rx_byte  = st_in.read_result;
      rsp_data_in.ack_bit  = st_in.ack;
   end

   // state, delay counter and config register
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.prim        <= PRIM_IDLE;
         st_ff.check_mode  <= 1'b0;
         st_ff.phase       <= 3'd0;
         st_ff.bit_index   <= 4'd0;
         st_ff.shift       <= 8'd0;
         st_ff.scl         <= 1'b1;
         st_ff.sda         <= 1'b1;
         st_ff.read_result <= 8'd0;
         st_ff.ack         <= 1'b1;
         st_ff.load_delay  <= 1'b0;
         st_ff.res         <= STEP_END;
         st_ff.done        <= 1'b0;
         delay_ff          <= '0;
         half_period_ff    <= HALF_PERIOD_RESET;
      end else begin
         if (req_fire) begin
            st_ff    <= st_in;
            delay_ff <= delay_in;
         end
         if (csr_write_en) begin
            half_period_ff <= csr_write_data;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

[sim/i2c_master_bit_engine_tb.sv]
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_tb
// Self-checking bench for the I2C master bit engine. Every req beat is one
// bus tick; a scoreboard class mirrors the line sequencer tick by tick and
// compares each rsp beat field by field. Directed commands come first, then
// random transfers, probes and noise under several half periods and
// handshake idling mixes, including a long rsp hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import i2cm_pkg::*;

   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 5000;

   // kinds outside the command set, taken as no command
   localparam logic [3:0] KIND_UNKNOWN_LOW  = 4'd9;
   localparam logic [3:0] KIND_UNKNOWN_HIGH = 4'd15;

   // mirror of the line sequencer plus the queue of predicted rsp beats
   class bit_engine_scoreboard;
      logic [15:0]     half_period;
      logic [15:0]     delay_left;
      logic [2:0]      seq_phase;
      logic [3:0]      bit_count;
      logic [7:0]      shift_bits;
      kind_type        cmd_active;
      kind_type        seq_prim;
      logic            scl_drive;
      logic            sda_drive;
      logic [7:0]      last_read;
      logic            ack_seen;
      rsp_payload_type expected_line_beats[$];
      int              mismatches;

      function new();
         half_period = HALF_PERIOD_RESET;
         delay_left  = '0;
         seq_phase   = '0;
         bit_count   = '0;
         shift_bits  = '0;
         cmd_active  = KIND_NONE;
         seq_prim    = KIND_NONE;
         scl_drive   = 1'b1;
         sda_drive   = 1'b1;
         last_read   = '0;
         ack_seen    = 1'b1;
         mismatches  = 0;
      endfunction

      function bit engine_busy();
         return cmd_active != KIND_NONE;
      endfunction

      function int pending();
         return expected_line_beats.size();
      endfunction

      // hold the current levels for one bus delay, zero acts as one
      function void hold_level(logic [2:0] next_phase);
         logic [15:0] ticks;
         ticks      = (half_period == 16'd0) ? 16'd1 : half_period;
         delay_left = ticks - 16'd1;
         seq_phase  = next_phase;
      endfunction

      // one step of the running line sequence
      function step_res_type run_phase(logic sda);
         step_res_type res;
         res = STEP_DELAY;
         case (seq_prim)
            KIND_START: begin
               if (seq_phase == 0) begin
                  sda_drive = 1'b1;
                  scl_drive = 1'b1;
                  hold_level(3'd1);
               end else if (seq_phase == 1) begin
                  sda_drive = 1'b0;
                  hold_level(3'd2);
               end else if (seq_phase == 2) begin
                  scl_drive = 1'b0;
                  hold_level(3'd3);
               end else res = STEP_END;
            end
            KIND_STOP: begin
               if (seq_phase == 0) begin
                  sda_drive = 1'b0;
                  hold_level(3'd1);
               end else if (seq_phase == 1) begin
                  scl_drive = 1'b1;
                  hold_level(3'd2);
               end else if (seq_phase == 2) begin
                  sda_drive = 1'b1;
                  hold_level(3'd3);
               end else res = STEP_END;
            end
            KIND_WRITE: begin
               if (seq_phase == 0) begin
                  sda_drive = shift_bits[7];
                  hold_level(3'd1);
               end else if (seq_phase == 1) begin
                  scl_drive = 1'b1;
                  hold_level(3'd2);
               end else begin
                  // clock low, release sda after the last bit, no trailing delay
                  scl_drive = 1'b0;
                  if (bit_count >= LAST_BIT) sda_drive = 1'b1;
                  shift_bits = shift_bits << 1;
                  bit_count  = bit_count + 4'd1;
                  if (bit_count >= BYTE_BITS) res = STEP_END;
                  else begin
                     seq_phase = 3'd0;
                     res       = STEP_GO;
                  end
               end
            end
            KIND_READ: begin
               if (seq_phase == 0) begin
                  scl_drive = 1'b1;
                  hold_level(3'd1);
               end else if (seq_phase == 1) begin
                  shift_bits = {shift_bits[6:0], sda};
                  scl_drive  = 1'b0;
                  bit_count  = bit_count + 4'd1;
                  hold_level(3'd2);
               end else if (bit_count >= BYTE_BITS) begin
                  last_read = shift_bits;
                  res       = STEP_END;
               end else begin
                  seq_phase = 3'd0;
                  res       = STEP_GO;
               end
            end
            KIND_WAITACK: begin
               if (seq_phase == 0) begin
                  sda_drive = 1'b1;
                  hold_level(3'd1);
               end else if (seq_phase == 1) begin
                  scl_drive = 1'b1;
                  hold_level(3'd2);
               end else if (seq_phase == 2) begin
                  ack_seen  = sda;
                  scl_drive = 1'b0;
                  hold_level(3'd3);
               end else res = STEP_END;
            end
            KIND_ACK, KIND_NACK: begin
               if (seq_phase == 0) begin
                  sda_drive = (seq_prim == KIND_ACK) ? 1'b0 : 1'b1;
                  hold_level(3'd1);
               end else if (seq_phase == 1) begin
                  scl_drive = 1'b1;
                  hold_level(3'd2);
               end else if (seq_phase == 2) begin
                  scl_drive = 1'b0;
                  hold_level(3'd3);
               end else if (seq_phase == 3 && seq_prim == KIND_ACK) begin
                  sda_drive = 1'b1;
                  hold_level(3'd4);
               end else res = STEP_END;
            end
            default: res = STEP_END;
         endcase
         return res;
      endfunction

      // run steps until a delay starts or the command ends
      function bit advance(logic sda);
         step_res_type res;
         bit           finished;
         finished = 1'b0;
         do begin
            res = run_phase(sda);
            if (res == STEP_END) begin
               if (cmd_active == KIND_CHECK && seq_prim != KIND_STOP) begin
                  // device probe chains start, address write, ack wait, stop
                  case (seq_prim)
                     KIND_START: seq_prim = KIND_WRITE;
                     KIND_WRITE: seq_prim = KIND_WAITACK;
                     default:    seq_prim = KIND_STOP;
                  endcase
                  seq_phase = 3'd0;
                  bit_count = 4'd0;
                  res       = STEP_GO;
               end else begin
                  cmd_active = KIND_NONE;
                  seq_prim   = KIND_NONE;
                  seq_phase  = 3'd0;
                  finished   = 1'b1;
               end
            end
         end while (res == STEP_GO);
         return finished;
      endfunction

      // one accepted tick: advance the mirror and queue the predicted beat
      function void note_req(req_payload_type beat);
         rsp_payload_type predicted;
         logic            done;
         done = 1'b0;
         if (cmd_active != KIND_NONE) begin
            if (delay_left != 0) delay_left = delay_left - 16'd1;
            else done = advance(beat.sda_in);
         end else if (beat.kind >= KIND_START && beat.kind <= KIND_CHECK) begin
            bit_count = 4'd0;
            seq_phase = 3'd0;
            if (beat.kind == KIND_CHECK) begin
               if (beat.sda_in && beat.scl_in) begin
                  cmd_active = KIND_CHECK;
                  seq_prim   = KIND_START;
                  shift_bits = beat.data_byte;
                  done       = advance(beat.sda_in);
               end else begin
                  // bus not idle: no response, lines untouched
                  ack_seen = 1'b1;
                  done     = 1'b1;
               end
            end else begin
               cmd_active = kind_type'(beat.kind);
               seq_prim   = kind_type'(beat.kind);
               if (beat.kind == KIND_WRITE) shift_bits = beat.data_byte;
               if (beat.kind == KIND_READ) shift_bits = '0;
               done = advance(beat.sda_in);
            end
         end
         predicted.scl_out  = scl_drive;
         predicted.sda_out  = sda_drive;
         predicted.busy_res = (cmd_active != KIND_NONE);
         predicted.done_res = done;
         predicted.rx_byte  = last_read;
         predicted.ack_bit  = ack_seen;
         expected_line_beats.push_back(predicted);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
         end
      endfunction

      // one accepted rsp beat against the oldest prediction
      function void check_rsp(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_line_beats.size() == 0) begin
            $error("rsp beat with nothing predicted: %h", got);
            mismatches++;
            return;
         end
         want = expected_line_beats.pop_front();
         compare_field("scl_out", 8'(want.scl_out), 8'(got.scl_out));
         compare_field("sda_out", 8'(want.sda_out), 8'(got.sda_out));
         compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
         compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
         compare_field("rx_byte", want.rx_byte, got.rx_byte);
         compare_field("ack_bit", 8'(want.ack_bit), 8'(got.ack_bit));
      endfunction
   endclass

   logic            clock = 1'b0;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_data;
   logic            csr_write_en;
   logic [15:0]     csr_write_data;

   bit_engine_scoreboard engine_sb;
   int send_gap_pct;
   int recv_gap_pct;
   bit hold_req;
   int items_sent;

   i2c_master_bit_engine u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // rsp side: random stalls, or one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_gap_pct);
         end
      end
   end

   // check every rsp beat taken
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) engine_sb.check_rsp(rsp_data);
   end

   // watchdog on cycles with no beat moving on either side
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(255));
   endfunction

   function automatic logic rand_bit();
      return 1'($urandom_range(1));
   endfunction

   function automatic req_payload_type random_beat();
      req_payload_type beat;
      beat.kind      = 4'($urandom_range(15));
      beat.data_byte = rand_byte();
      beat.sda_in    = rand_bit();
      beat.scl_in    = rand_bit();
      return beat;
   endfunction

   // offer one tick, note it in the scoreboard when taken
   task automatic send_beat(input req_payload_type beat);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      engine_sb.note_req(beat);
      items_sent++;
   endtask

   // issue a command on an idle engine, then tick with noise until it is done
   task automatic run_command(input logic [3:0] kind, input logic [7:0] data,
                              input logic sda, input logic scl);
      req_payload_type beat;
      beat.kind      = kind;
      beat.data_byte = data;
      beat.sda_in    = sda;
      beat.scl_in    = scl;
      send_beat(beat);
      while (engine_sb.engine_busy()) send_beat(random_beat());
   endtask

   // stop offering until every predicted beat has come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (engine_sb.pending() != 0);
   endtask

   // new half period, only with the engine idle and the rsp side empty
   task automatic set_half_period(input logic [15:0] value);
      while (engine_sb.engine_busy()) send_beat(random_beat());
      drain();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      engine_sb.half_period = value;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // start, address, ack, a data byte or two, stop
   task automatic random_transfer();
      logic [7:0] addr;
      int         n_bytes;
      addr    = rand_byte();
      n_bytes = $urandom_range(1, 2);
      run_command(KIND_START, rand_byte(), rand_bit(), rand_bit());
      run_command(KIND_WRITE, addr, rand_bit(), rand_bit());
      run_command(KIND_WAITACK, rand_byte(), rand_bit(), rand_bit());
      for (int i = 0; i < n_bytes; i++) begin
         if (addr[0]) begin
            run_command(KIND_READ, rand_byte(), rand_bit(), rand_bit());
            run_command((i == n_bytes - 1) ? KIND_NACK : KIND_ACK, rand_byte(),
                        rand_bit(), rand_bit());
         end else begin
            run_command(KIND_WRITE, rand_byte(), rand_bit(), rand_bit());
            run_command(KIND_WAITACK, rand_byte(), rand_bit(), rand_bit());
         end
      end
      run_command(KIND_STOP, rand_byte(), rand_bit(), rand_bit());
   endtask

   // mix of transfers, probes, stray kinds and broken sequences, by beat count
   task automatic random_phase(input int n_items);
      int target;
      target = items_sent + n_items;
      while (items_sent < target) begin
         case ($urandom_range(9))
            0, 1, 2: random_transfer();
            3, 4: run_command(KIND_CHECK, rand_byte(), $urandom_range(3) != 0,
                              $urandom_range(3) != 0);
            5, 6: run_command(4'($urandom_range(15)), rand_byte(), rand_bit(),
                              rand_bit());
            default: begin
               run_command(4'($urandom_range(KIND_START, KIND_NACK)), rand_byte(),
                           rand_bit(), rand_bit());
            end
         endcase
      end
   endtask

   initial begin
      engine_sb      = new();
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_ready      = 1'b0;
      csr_write_en   = 1'b0;
      csr_write_data = '0;
      send_gap_pct   = 0;
      recv_gap_pct   = 0;
      hold_req       = 1'b0;
      items_sent     = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: every command and the data extremes at the shortest delay
      send_gap_pct = 17;
      recv_gap_pct = 51;
      set_half_period(16'd1);
      run_command(KIND_START, 8'h00, 1'b1, 1'b1);
      run_command(KIND_WRITE, 8'hFF, 1'b0, 1'b1);
      run_command(KIND_WAITACK, 8'h00, 1'b0, 1'b0);
      run_command(KIND_WRITE, 8'h00, 1'b1, 1'b0);
      run_command(KIND_WAITACK, 8'hFF, 1'b1, 1'b1);
      run_command(KIND_READ, 8'hFF, 1'b1, 1'b1);
      run_command(KIND_ACK, 8'h00, 1'b0, 1'b1);
      run_command(KIND_READ, 8'h00, 1'b0, 1'b0);
      run_command(KIND_NACK, 8'hFF, 1'b1, 1'b0);
      run_command(KIND_STOP, 8'h5A, 1'b0, 1'b1);
      run_command(KIND_CHECK, 8'h00, 1'b1, 1'b1);
      run_command(KIND_CHECK, 8'hFF, 1'b1, 1'b1);
      // probe with the bus not idle
      run_command(KIND_CHECK, 8'hA0, 1'b0, 1'b1);
      run_command(KIND_CHECK, 8'hA0, 1'b1, 1'b0);
      run_command(KIND_CHECK, 8'hA0, 1'b0, 1'b0);
      // kinds outside the command set and no command
      run_command(KIND_UNKNOWN_LOW, 8'hFF, 1'b1, 1'b1);
      run_command(KIND_UNKNOWN_HIGH, 8'h00, 1'b0, 1'b0);
      run_command(KIND_NONE, 8'hA5, 1'b1, 1'b1);
      run_command(KIND_WRITE, 8'hA5, 1'b1, 1'b1);

      // directed: zero half period behaves as one
      set_half_period(16'd0);
      run_command(KIND_START, 8'h00, 1'b1, 1'b1);
      run_command(KIND_READ, 8'h00, 1'b1, 1'b1);
      run_command(KIND_STOP, 8'h00, 1'b1, 1'b1);

      // random, sender idles less than receiver, with a long rsp hold-off
      set_half_period(16'd2);
      random_phase(20);
      hold_req = 1'b1;
      random_phase(20);

      // random, receiver idles less than sender, with a full pause
      send_gap_pct = 51;
      recv_gap_pct = 17;
      set_half_period(16'd1);
      random_phase(20);
      drain();
      set_half_period(16'd2);
      random_phase(20);

      // random, no idling on either side
      send_gap_pct = 0;
      recv_gap_pct = 0;
      set_half_period(16'd1);
      random_phase(30);

      // longer delay, one short command
      set_half_period(16'd5);
      run_command(KIND_START, 8'h00, 1'b1, 1'b1);

      drain();
      repeat (4) @(posedge clock);
      if (engine_sb.mismatches == 0 && engine_sb.pending() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire
